@@ hw/rtl/awwa_pkg.sv @@
// Shared types and constants of the address wait and wake arbiter.
// Used by the channel interfaces, the slot cell and the top level; no dependencies.
package awwa_pkg;

    localparam int THREAD_SLOTS_DEF = 16;
    localparam int MAX_WAKE         = 16;
    localparam int WAKE_W           = $clog2(MAX_WAKE + 1);
    localparam int ADDR_W           = 32;
    localparam int DATA_W           = 32;
    localparam int PRIO_W           = 6;

    localparam logic [2:0] OP_SIGNAL       = 3'd0;
    localparam logic [2:0] OP_WAIT_LT      = 3'd1;
    localparam logic [2:0] OP_DEC_WAIT_LT  = 3'd2;
    localparam logic [2:0] OP_WAIT_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_DEC_TIMEOUT  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ST_UNALIGNED  = 3'd3;
    localparam logic [2:0] ST_UNIMPL     = 3'd4;

    typedef struct packed {
        logic [2:0]               opcode;
        logic                     handle_valid;
        logic [3:0]               thread_slot;
        logic [PRIO_W-1:0]        caller_priority;
        logic [ADDR_W-1:0]        wait_address;
        logic signed [DATA_W-1:0] arg_value;
        logic signed [DATA_W-1:0] memory_word;
    } req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic                     slept;
        logic                     write_enable;
        logic signed [DATA_W-1:0] write_data;
        logic                     woken_valid;
        logic [3:0]               woken_slot;
        logic                     reschedule;
        logic                     last;
    } rsp_t;

    // Command broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic              park;
        logic              wake;
        logic [ADDR_W-1:0] addr;
        logic [PRIO_W-1:0] prio;
    } cell_cmd_t;

    // Best candidate found so far, handed from cell to cell.
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
    } search_t;

endpackage

@@ hw/rtl/awwa_if.sv @@
// Valid/ready channel interfaces for requests and results of the arbiter.
// Depends on awwa_pkg for the payload types.
interface awwa_req_if;
    logic          valid;
    logic          ready;
    awwa_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface awwa_rsp_if;
    logic          valid;
    logic          ready;
    awwa_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/awwa_cell.sv @@
// One thread slot of the arbiter: waiting mark, wait address and priority,
// plus one stage of the search wave. Depends on awwa_pkg.
module awwa_cell #(
    parameter int SLOT_W     = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  awwa_pkg::cell_cmd_t          cmd,
    input  logic [SLOT_W-1:0]            cmd_idx,
    input  logic [awwa_pkg::ADDR_W-1:0]  match_addr,
    input  awwa_pkg::search_t            tok_in,
    input  logic [SLOT_W-1:0]            idx_in,
    output awwa_pkg::search_t            tok_out,
    output logic [SLOT_W-1:0]            idx_out
);

    logic                          waiting_reg;
    logic                          waiting_next;
    logic [awwa_pkg::ADDR_W-1:0]   addr_reg;
    logic [awwa_pkg::PRIO_W-1:0]   prio_reg;
    awwa_pkg::search_t             tok_reg;
    awwa_pkg::search_t             tok_next;
    logic [SLOT_W-1:0]             idx_reg;
    logic [SLOT_W-1:0]             idx_next;
    logic                          selected;
    logic                          better;

    assign selected = (cmd_idx == SLOT_W'(CELL_INDEX));

    always_comb
    begin
        waiting_next = waiting_reg;
        if (cmd.park && selected)
        begin
            waiting_next = 1'b1;
        end
        else if (cmd.wake && selected)
        begin
            waiting_next = 1'b0;
        end
    end

    // Ties keep the candidate from the lower slot.
    assign better = waiting_reg && (addr_reg == match_addr) &&
                    (!tok_in.found || (prio_reg < tok_in.prio));

    always_comb
    begin
        if (better)
        begin
            tok_next.found = 1'b1;
            tok_next.prio  = prio_reg;
            idx_next       = SLOT_W'(CELL_INDEX);
        end
        else
        begin
            tok_next = tok_in;
            idx_next = idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            waiting_reg <= waiting_next;
            tok_reg     <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.park && selected)
        begin
            addr_reg <= cmd.addr;
            prio_reg <= cmd.prio;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

@@ hw/rtl/address_wait_wake_arbiter.sv @@
// Top level of the address wait and wake arbiter: request decode, sequencer,
// result register and the chain of slot cells. Depends on awwa_pkg, awwa_if, awwa_cell.
//
//   channel   dir   payload            handshake
//   req       in    awwa_pkg::req_t    valid/ready
//   rsp       out   awwa_pkg::rsp_t    valid/ready
//
// Errors and waits are decoded in the accept cycle and give one result in the next cycle.
// A signal with k woken threads runs k + 1 search waves when its last search finds no
// waiter, and k search waves when it reaches its count; each search wave has to pass
// every cell of the chain once.
// Reset clears all waiting marks at once and needs no clearing pass.
// A stalled result holds the sequencer and no new request is taken during a signal.
module address_wait_wake_arbiter #(
    parameter int THREAD_SLOTS = awwa_pkg::THREAD_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    awwa_req_if.sink    req,
    awwa_rsp_if.source  rsp
);

    localparam int SLOT_W = $clog2(THREAD_SLOTS);
    localparam int CNT_W  = $clog2(THREAD_SLOTS + 1);
    localparam logic [CNT_W-1:0] SCAN_DONE = CNT_W'(THREAD_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                                state_reg, state_next;
    logic [CNT_W-1:0]                      cnt_reg, cnt_next;
    logic [awwa_pkg::ADDR_W-1:0]           target_reg, target_next;
    logic [awwa_pkg::WAKE_W-1:0]           cap_reg, cap_next;
    logic [awwa_pkg::WAKE_W-1:0]           n_reg, n_next;
    logic                                  pend_v_reg, pend_v_next;
    logic [SLOT_W-1:0]                     pend_slot_reg, pend_slot_next;
    logic                                  out_valid_reg;
    awwa_pkg::rsp_t                        out_reg;
    awwa_pkg::rsp_t                        out_data;
    logic                                  out_load;
    logic                                  out_free;
    logic                                  accept;
    logic                                  slot_ok;
    awwa_pkg::req_t                        p;
    awwa_pkg::cell_cmd_t                   cmd;
    logic [SLOT_W-1:0]                     cmd_idx;
    awwa_pkg::search_t                     tok [THREAD_SLOTS+1];
    logic [SLOT_W-1:0]                     idx [THREAD_SLOTS+1];

    assign p        = req.payload;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept   = req.valid && req.ready;
    assign slot_ok  = (32'(p.thread_slot) < 32'(THREAD_SLOTS));

    assign tok[0] = '0;
    assign idx[0] = '0;

    for (genvar g = 0; g < THREAD_SLOTS; g++)
    begin : g_cell
        awwa_cell #(
            .SLOT_W     (SLOT_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .cmd_idx    (cmd_idx),
            .match_addr (target_reg),
            .tok_in     (tok[g]),
            .idx_in     (idx[g]),
            .tok_out    (tok[g+1]),
            .idx_out    (idx[g+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = (cnt_reg == SCAN_DONE) ? cnt_reg : cnt_reg + CNT_W'(1);
        target_next    = target_reg;
        cap_next       = cap_reg;
        n_next         = n_reg;
        pend_v_next    = pend_v_reg;
        pend_slot_next = pend_slot_reg;
        out_load       = 1'b0;
        out_data       = '0;
        cmd            = '0;
        cmd_idx        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_data.last = 1'b1;
                    if (!p.handle_valid)
                    begin
                        out_data.status = awwa_pkg::ST_BAD_HANDLE;
                        out_load        = 1'b1;
                    end
                    else if (p.wait_address[1:0] != 2'b00)
                    begin
                        out_data.status = awwa_pkg::ST_UNALIGNED;
                        out_load        = 1'b1;
                    end
                    else if (p.opcode > awwa_pkg::OP_DEC_TIMEOUT)
                    begin
                        out_data.status = awwa_pkg::ST_BAD_TYPE;
                        out_load        = 1'b1;
                    end
                    else if ((p.opcode == awwa_pkg::OP_WAIT_TIMEOUT) ||
                             (p.opcode == awwa_pkg::OP_DEC_TIMEOUT))
                    begin
                        out_data.status = awwa_pkg::ST_UNIMPL;
                        out_load        = 1'b1;
                    end
                    else if (p.opcode == awwa_pkg::OP_SIGNAL)
                    begin
                        if (p.arg_value == '0)
                        begin
                            out_load = 1'b1;
                        end
                        else
                        begin
                            target_next = p.wait_address;
                            if ((p.arg_value < 0) ||
                                (p.arg_value > $signed(32'(awwa_pkg::MAX_WAKE))))
                            begin
                                cap_next = awwa_pkg::WAKE_W'(awwa_pkg::MAX_WAKE);
                            end
                            else
                            begin
                                cap_next = p.arg_value[awwa_pkg::WAKE_W-1:0];
                            end
                            n_next      = '0;
                            pend_v_next = 1'b0;
                            cnt_next    = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    else
                    begin
                        out_load = 1'b1;
                        if ((p.memory_word < p.arg_value) && slot_ok)
                        begin
                            out_data.slept = 1'b1;
                            cmd.park       = 1'b1;
                            cmd.addr       = p.wait_address;
                            cmd.prio       = p.caller_priority;
                            cmd_idx        = SLOT_W'(p.thread_slot);
                            if (p.opcode == awwa_pkg::OP_DEC_WAIT_LT)
                            begin
                                out_data.write_enable = 1'b1;
                                out_data.write_data   = p.memory_word - 32'sd1;
                            end
                        end
                    end
                end
            end
            S_SCAN:
            begin
                out_data.woken_valid = pend_v_reg;
                out_data.woken_slot  = pend_v_reg ? 4'(pend_slot_reg) : 4'd0;
                if (pend_v_reg && (n_reg == cap_reg))
                begin
                    if (out_free)
                    begin
                        out_data.reschedule = 1'b1;
                        out_data.last       = 1'b1;
                        out_load            = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else if ((cnt_reg == SCAN_DONE) && out_free)
                begin
                    if (tok[THREAD_SLOTS].found)
                    begin
                        out_load       = pend_v_reg;
                        pend_v_next    = 1'b1;
                        pend_slot_next = idx[THREAD_SLOTS];
                        n_next         = n_reg + awwa_pkg::WAKE_W'(1);
                        cmd.wake       = 1'b1;
                        cmd_idx        = idx[THREAD_SLOTS];
                        cnt_next       = '0;
                    end
                    else
                    begin
                        out_data.reschedule = pend_v_reg;
                        out_data.last       = 1'b1;
                        out_load            = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            pend_v_reg <= pend_v_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg    <= target_next;
        cap_reg       <= cap_next;
        pend_slot_reg <= pend_slot_next;
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the address wait and wake arbiter: directed and random requests,
// each reply checked field by field against a slot table that the bench keeps itself.
// Depends on awwa_pkg, the awwa_req_if and awwa_rsp_if channels and address_wait_wake_arbiter.
module testbench;
    import awwa_pkg::*;

    localparam int          SLOTS        = THREAD_SLOTS_DEF;
    localparam logic [2:0]  OP_TOP       = 3'd7;
    localparam int          RANDOM_CALLS = 130;
    localparam int          TAIL_CALLS   = 30;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          DRAIN_CYCLES = 64;
    localparam logic [31:0] HOT_ADDR     = 32'h0000_1000;
    localparam logic [31:0] COLD_ADDR    = 32'hFFFF_FFFC;
    localparam logic [31:0] INT_MIN      = 32'h8000_0000;
    localparam logic [31:0] INT_MAX      = 32'h7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;

    awwa_req_if req_ch ();
    awwa_rsp_if rsp_ch ();

    address_wait_wake_arbiter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    req_t              pending_calls[$];
    rsp_t              awaited_replies[$];
    bit                parked[SLOTS];
    logic [ADDR_W-1:0] parked_addr[SLOTS];
    logic [PRIO_W-1:0] parked_prio[SLOTS];
    int                calls_queued   = 0;
    int                calls_accepted = 0;
    int                error_count    = 0;
    int                send_gap       = 0;
    int                hold_off       = 0;
    int                quiet_cycles   = 0;

    always #1 clk = ~clk;

    function automatic rsp_t reply_of(input logic [2:0] status, input logic slept,
                                      input logic we, input logic [31:0] wdata,
                                      input logic wv, input logic [3:0] wslot,
                                      input logic resched, input logic last);
        rsp_t r;
        r.status       = status;
        r.slept        = slept;
        r.write_enable = we;
        r.write_data   = wdata;
        r.woken_valid  = wv;
        r.woken_slot   = wslot;
        r.reschedule   = resched;
        r.last         = last;
        return r;
    endfunction

    // Applies one accepted request to the slot table and queues the replies it must produce.
    task automatic arbitrate(input req_t call);
        int woken[$];
        int best;
        bit searching;
        bit final_one;
        if (!call.handle_valid)
            awaited_replies.push_back(reply_of(ST_BAD_HANDLE, 0, 0, '0, 0, '0, 0, 1));
        else if (call.wait_address[1:0] != 2'b00)
            awaited_replies.push_back(reply_of(ST_UNALIGNED, 0, 0, '0, 0, '0, 0, 1));
        else if (call.opcode > OP_DEC_TIMEOUT)
            awaited_replies.push_back(reply_of(ST_BAD_TYPE, 0, 0, '0, 0, '0, 0, 1));
        else if (call.opcode == OP_WAIT_TIMEOUT || call.opcode == OP_DEC_TIMEOUT)
            awaited_replies.push_back(reply_of(ST_UNIMPL, 0, 0, '0, 0, '0, 0, 1));
        else if (call.opcode == OP_SIGNAL)
        begin
            searching = (call.arg_value != 0);
            while (searching && woken.size() < MAX_WAKE &&
                   (call.arg_value < 0 || woken.size() < call.arg_value))
            begin
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (parked[i] && parked_addr[i] == call.wait_address &&
                        (best < 0 || parked_prio[i] < parked_prio[best]))
                        best = i;
                if (best < 0)
                    searching = 1'b0;
                else
                begin
                    parked[best] = 1'b0;
                    woken.push_back(best);
                end
            end
            if (woken.size() == 0)
                awaited_replies.push_back(reply_of(ST_OK, 0, 0, '0, 0, '0, 0, 1));
            foreach (woken[k])
            begin
                final_one = (k == woken.size() - 1);
                awaited_replies.push_back(reply_of(ST_OK, 0, 0, '0, 1, 4'(woken[k]),
                                                   final_one, final_one));
            end
        end
        else if (call.memory_word < call.arg_value && call.thread_slot < SLOTS)
        begin
            parked[call.thread_slot]      = 1'b1;
            parked_addr[call.thread_slot] = call.wait_address;
            parked_prio[call.thread_slot] = call.caller_priority;
            awaited_replies.push_back(reply_of(ST_OK, 1, call.opcode == OP_DEC_WAIT_LT,
                (call.opcode == OP_DEC_WAIT_LT) ? 32'(call.memory_word - 1) : 32'd0,
                0, '0, 0, 1));
        end
        else
            awaited_replies.push_back(reply_of(ST_OK, 0, 0, '0, 0, '0, 0, 1));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_reply(input rsp_t got);
        rsp_t want;
        if (awaited_replies.size() == 0)
        begin
            $error("reply with no request outstanding: %0h", got);
            error_count++;
        end
        else
        begin
            want = awaited_replies.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("slept", 32'(want.slept), 32'(got.slept));
            check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
            check_field("write_data", want.write_data, got.write_data);
            check_field("woken_valid", 32'(want.woken_valid), 32'(got.woken_valid));
            check_field("woken_slot", 32'(want.woken_slot), 32'(got.woken_slot));
            check_field("reschedule", 32'(want.reschedule), 32'(got.reschedule));
            check_field("last", 32'(want.last), 32'(got.last));
        end
    endtask

    task automatic add_call(input logic [2:0] op, input logic hv, input logic [3:0] slot,
                            input logic [5:0] prio, input logic [31:0] addr,
                            input logic [31:0] value, input logic [31:0] word);
        req_t call;
        call.opcode          = op;
        call.handle_valid    = hv;
        call.thread_slot     = slot;
        call.caller_priority = prio;
        call.wait_address    = addr;
        call.arg_value       = value;
        call.memory_word     = word;
        pending_calls.push_back(call);
        calls_queued++;
    endtask

    // Mostly parks the caller; priorities are often squeezed together to force ties.
    task automatic add_random_wait(input logic [31:0] addr);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] value;
        logic [31:0] word;
        a = $urandom;
        b = $urandom;
        if ($urandom_range(0, 7) != 0 && $signed(a) >= $signed(b))
        begin
            word  = b;
            value = a;
        end
        else
        begin
            word  = a;
            value = b;
        end
        add_call($urandom_range(0, 1) ? OP_DEC_WAIT_LT : OP_WAIT_LT, 1'b1,
                 4'($urandom_range(0, SLOTS - 1)),
                 6'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 63)),
                 addr, value, word);
    endtask

    function automatic bit in_tail();
        return pending_calls.size() <= TAIL_CALLS;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                arbitrate(req_ch.payload);
                calls_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_calls.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (!in_tail() && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 15);
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    req_ch.payload <= pending_calls.pop_front();
                    req_ch.valid   <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_reply(rsp_ch.payload);
            if (hold_off > 0)
            begin
                hold_off--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!in_tail() && $urandom_range(0, 5) == 0)
            begin
                hold_off = $urandom_range(0, 15);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] pool[4];
        logic [31:0] addr;
        logic [31:0] count;
        int          random_calls;
        int          waiters;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        rst_n          = 1'b0;

        // Error checks in their priority order, then parks, ties and overwrites on one word, and signals.
        add_call(OP_TOP, 1'b0, 4'd15, 6'd63, 32'hFFFF_FFFF, -1, -1);
        for (int low = 1; low < 4; low++)
            add_call(OP_TOP, 1'b1, 4'd0, 6'd0, HOT_ADDR | low, 0, 0);
        for (int op = OP_DEC_TIMEOUT + 1; op <= OP_TOP; op++)
            add_call(3'(op), 1'b1, 4'd0, 6'd0, HOT_ADDR, 1, 0);
        add_call(OP_WAIT_TIMEOUT, 1'b1, 4'd6, 6'd1, HOT_ADDR, 1, 0);
        add_call(OP_DEC_TIMEOUT, 1'b1, 4'd6, 6'd1, HOT_ADDR, 1, 0);
        add_call(OP_SIGNAL, 1'b1, 4'd0, 6'd0, HOT_ADDR, -1, 0);
        add_call(OP_WAIT_LT, 1'b1, 4'd1, 6'd5, HOT_ADDR, 7, 7);
        add_call(OP_WAIT_LT, 1'b1, 4'd1, 6'd5, HOT_ADDR, 0, -1);
        add_call(OP_DEC_WAIT_LT, 1'b1, 4'd2, 6'd5, HOT_ADDR, INT_MAX, INT_MIN);
        add_call(OP_DEC_WAIT_LT, 1'b1, 4'd3, 6'd5, HOT_ADDR, INT_MIN, INT_MAX);
        add_call(OP_DEC_WAIT_LT, 1'b1, 4'd15, 6'd0, HOT_ADDR, 1, 0);
        add_call(OP_WAIT_LT, 1'b1, 4'd0, 6'd63, COLD_ADDR, 1, 0);
        add_call(OP_WAIT_LT, 1'b1, 4'd4, 6'd5, HOT_ADDR, 1, 0);
        add_call(OP_WAIT_LT, 1'b1, 4'd0, 6'd5, HOT_ADDR, 1, 0);
        add_call(OP_SIGNAL, 1'b1, 4'd0, 6'd0, HOT_ADDR, 0, 0);
        add_call(OP_SIGNAL, 1'b1, 4'd0, 6'd0, HOT_ADDR, 1, 0);
        add_call(OP_SIGNAL, 1'b1, 4'd0, 6'd0, HOT_ADDR, 2, 0);
        add_call(OP_SIGNAL, 1'b1, 4'd0, 6'd0, COLD_ADDR, -1, 0);
        add_call(OP_SIGNAL, 1'b1, 4'd0, 6'd0, HOT_ADDR, INT_MAX, 0);

        pool[0] = 32'h0;
        pool[1] = COLD_ADDR;
        pool[2] = $urandom & ~32'h3;
        pool[3] = $urandom & ~32'h3;
        random_calls = 0;
        while (random_calls < RANDOM_CALLS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // A group of waiters on one word, then a signal request on that word with a random count.
                addr    = pool[$urandom_range(0, 3)];
                waiters = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 16)
                                                      : $urandom_range(1, 4);
                repeat (waiters)
                    add_random_wait(addr);
                case ($urandom_range(0, 4))
                    0: count = $urandom | INT_MIN;
                    1: count = 0;
                    2: count = $urandom_range(1, waiters);
                    3: count = $urandom & INT_MAX;
                    default: count = $urandom_range(1, 3);
                endcase
                add_call(OP_SIGNAL, 1'b1, 4'($urandom_range(0, SLOTS - 1)),
                         6'($urandom_range(0, 63)), addr, count, $urandom);
                random_calls += waiters + 1;
            end
            else
            begin
                add_call(3'($urandom_range(0, 7)), $urandom_range(0, 3) != 0,
                         4'($urandom_range(0, SLOTS - 1)), 6'($urandom_range(0, 63)),
                         $urandom_range(0, 1) ? $urandom : pool[$urandom_range(0, 3)],
                         $urandom, $urandom);
                random_calls++;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (calls_accepted < calls_queued)
            @(posedge clk);
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

@@ address_wait_wake_arbiter.f @@
hw/rtl/awwa_pkg.sv
hw/rtl/awwa_if.sv
hw/rtl/awwa_cell.sv
hw/rtl/address_wait_wake_arbiter.sv
bench/testbench.sv
